### src/mfig_pkg.sv
package mfig_pkg;

  localparam int unsigned MaxNodes = 64;
  localparam int unsigned MaxArcs  = 1024;
  localparam int unsigned CapBits  = 16;

  localparam int unsigned NodeW = $clog2(MaxNodes);
  localparam int unsigned ArcW  = $clog2(MaxArcs);
  localparam int unsigned PtrW  = ArcW + 1;
  localparam int unsigned RankW = $clog2(MaxNodes + 1);
  localparam int unsigned FlowW = 25;
  localparam int unsigned AugW  = 30;
  localparam int unsigned WordW = NodeW + CapBits + PtrW;

  localparam logic [PtrW-1:0]  ArcNone  = PtrW'(MaxArcs);
  localparam logic [AugW-1:0]  AugStart = AugW'(32'h3f3f3f3f);
  localparam logic [RankW-1:0] NodesMax = RankW'(MaxNodes);

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_RUN   = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_NODE_COUNT = 2'd0,
    CFG_SOURCE     = 2'd1,
    CFG_SINK       = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  typedef enum logic [28:0] {
    S_IDLE    = 29'd1 << 0,
    S_ADD0    = 29'd1 << 1,
    S_ADD1    = 29'd1 << 2,
    S_ADD2    = 29'd1 << 3,
    S_INIT_A  = 29'd1 << 4,
    S_INIT_B  = 29'd1 << 5,
    S_START   = 29'd1 << 6,
    S_TOP     = 29'd1 << 7,
    S_TOP_W   = 29'd1 << 8,
    S_ADV_W   = 29'd1 << 9,
    S_ADV_ARC = 29'd1 << 10,
    S_ADV_AW  = 29'd1 << 11,
    S_ADV_RW  = 29'd1 << 12,
    S_AUG     = 29'd1 << 13,
    S_AUG_P   = 29'd1 << 14,
    S_AUG_C   = 29'd1 << 15,
    S_AUG_E   = 29'd1 << 16,
    S_AUG_F   = 29'd1 << 17,
    S_RL      = 29'd1 << 18,
    S_RL_W    = 29'd1 << 19,
    S_RL_ARC  = 29'd1 << 20,
    S_RL_AW   = 29'd1 << 21,
    S_RL_RW   = 29'd1 << 22,
    S_RL_END  = 29'd1 << 23,
    S_RL_T    = 29'd1 << 24,
    S_RL_T2   = 29'd1 << 25,
    S_RL_T3   = 29'd1 << 26,
    S_RL_P    = 29'd1 << 27,
    S_DONE    = 29'd1 << 28
  } state_e;

endpackage

### src/mfig_req_if.sv
interface mfig_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   func;
  logic [mfig_pkg::NodeW-1:0]   from_node;
  logic [mfig_pkg::NodeW-1:0]   to_node;
  logic [15:0]                  capacity;

  modport source (output valid, func, from_node, to_node, capacity, input ready);
  modport sink (input valid, func, from_node, to_node, capacity, output ready);
endinterface

### src/mfig_rsp_if.sv
interface mfig_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [mfig_pkg::FlowW-1:0]   flow_value;

  modport source (output valid, status, flow_value, input ready);
  modport sink (input valid, status, flow_value, output ready);
endinterface

### src/max_flow_isap_gap_top.sv
// Clear, no-op and an add edge on a full table go straight to the result.
// Run: per-node setup of ranks, tallies and current arcs, then a data-dependent walk
// of arc visits and augment steps, all through the one read and one write port of the
// arc table. One request at a time; the next is taken once the result is loaded.
// Reset (async, active low) empties the graph and loads node count 64, source 0, sink 63.
module max_flow_isap_gap_top (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [6:0]            cfg_data_i,
  mfig_req_if.sink              req_i,
  mfig_rsp_if.source            rsp_o
);
  import mfig_pkg::*;

  // configuration
  logic [RankW-1:0] node_count_q;
  logic [NodeW-1:0] source_q, sink_q;

  // control and datapath registers
  state_e           state_q;
  logic [RankW-1:0] idx_q, nv_q, ru_q, minr_q, nr_q;
  logic [NodeW-1:0] u_q, v_q, w_q, from_q, to_q;
  logic [CapBits-1:0] cap_q, res_q;
  logic [PtrW-1:0]  a_q, link_q, fill_q;
  logic [ArcW-1:0]  e_q;
  logic [AugW-1:0]  aug_q;
  logic [FlowW-1:0] flow_q;
  logic             st_q, ovld_q;
  logic [MaxNodes-1:0] fa_vld_q;

  // memories
  logic [WordW-1:0] arc_mem [MaxArcs];
  logic [PtrW-1:0]  fa_mem [MaxNodes];
  logic [RankW-1:0] rk_mem [MaxNodes];
  logic [PtrW-1:0]  cu_mem [MaxNodes];
  logic [NodeW-1:0] pr_mem [MaxNodes];
  logic [RankW-1:0] tl_mem [MaxNodes+1];

  logic [WordW-1:0] arc_q;
  logic [PtrW-1:0]  fa_q, cu_q;
  logic             fa_vld_rd_q;
  logic [RankW-1:0] rk_q, tl_q;
  logic [NodeW-1:0] pr_q;

  logic             arc_we, fa_we, rk_we, cu_we, pr_we, tl_we;
  logic [ArcW-1:0]  arc_raddr, arc_waddr;
  logic [WordW-1:0] arc_wdata;
  logic [NodeW-1:0] fa_raddr, fa_waddr, rk_raddr, rk_waddr, cu_raddr, cu_waddr;
  logic [NodeW-1:0] pr_raddr, pr_waddr;
  logic [PtrW-1:0]  fa_wdata, cu_wdata;
  logic [RankW-1:0] rk_wdata, tl_raddr, tl_waddr, tl_wdata;
  logic [NodeW-1:0] pr_wdata;

  // decoded arc word and derived values
  logic [NodeW-1:0]   arc_tgt;
  logic [CapBits-1:0] arc_res;
  logic [PtrW-1:0]    arc_lnk;
  logic               arc_ok;
  logic [RankW-1:0]   nv_cfg, tl_dec, nr_c;
  logic [AugW-1:0]    aug_n;
  logic [PtrW-1:0]    fa_ptr;
  logic               req_fire;
  logic               rsp_load;
  logic               add_full, run_skip;

  assign arc_tgt = arc_q[WordW-1 -: NodeW];
  assign arc_res = arc_q[PtrW +: CapBits];
  assign arc_lnk = arc_q[PtrW-1:0];
  assign arc_ok  = ({1'b0, arc_tgt} < nv_q) && (arc_res != '0);
  assign fa_ptr  = fa_vld_rd_q ? fa_q : ArcNone;
  assign tl_dec  = tl_q - RankW'(1);
  assign nr_c    = (minr_q + RankW'(1) > nv_q) ? nv_q : minr_q + RankW'(1);
  assign aug_n   = ({{(AugW-CapBits){1'b0}}, res_q} < aug_q) ?
                   {{(AugW-CapBits){1'b0}}, res_q} : aug_q;
  assign nv_cfg  = (node_count_q < RankW'(2)) ? RankW'(2) :
                   (node_count_q > NodesMax) ? NodesMax : node_count_q;
  assign add_full = (fill_q > PtrW'(MaxArcs - 2));
  assign run_skip = ({1'b0, source_q} >= nv_cfg) || ({1'b0, sink_q} >= nv_cfg) ||
                    (source_q == sink_q);

  assign req_fire      = req_i.valid && req_i.ready;
  assign req_i.ready   = (state_q == S_IDLE);
  assign rsp_o.valid   = ovld_q;
  assign rsp_load      = (state_q == S_DONE) && (!ovld_q || rsp_o.ready);

  logic             rsp_st_q;
  logic [FlowW-1:0] rsp_flow_q;
  assign rsp_o.status     = rsp_st_q;
  assign rsp_o.flow_value = rsp_flow_q;

  // memory port addressing per state
  always_comb begin
    arc_we = 1'b0; arc_raddr = '0; arc_waddr = '0; arc_wdata = '0;
    fa_we = 1'b0; fa_raddr = '0; fa_waddr = '0; fa_wdata = '0;
    rk_we = 1'b0; rk_raddr = '0; rk_waddr = '0; rk_wdata = '0;
    cu_we = 1'b0; cu_raddr = '0; cu_waddr = '0; cu_wdata = '0;
    pr_we = 1'b0; pr_raddr = '0; pr_waddr = '0; pr_wdata = '0;
    tl_we = 1'b0; tl_raddr = '0; tl_waddr = '0; tl_wdata = '0;
    unique case (state_q)
      S_IDLE: fa_raddr = req_i.from_node;
      S_ADD0: begin
        arc_we = 1'b1; arc_waddr = fill_q[ArcW-1:0];
        arc_wdata = {to_q, cap_q, fa_ptr};
        fa_we = 1'b1; fa_waddr = from_q; fa_wdata = fill_q;
      end
      S_ADD1: fa_raddr = to_q;
      S_ADD2: begin
        arc_we = 1'b1; arc_waddr = fill_q[ArcW-1:0] | ArcW'(1);
        arc_wdata = {from_q, {CapBits{1'b0}}, fa_ptr};
        fa_we = 1'b1; fa_waddr = to_q; fa_wdata = fill_q | PtrW'(1);
      end
      S_INIT_A: begin
        fa_raddr = idx_q[NodeW-1:0];
        tl_we = 1'b1; tl_waddr = idx_q;
        rk_we = (idx_q < NodesMax); rk_waddr = idx_q[NodeW-1:0];
      end
      S_INIT_B: begin
        cu_we = (idx_q < NodesMax); cu_waddr = idx_q[NodeW-1:0]; cu_wdata = fa_ptr;
      end
      S_START: begin
        tl_we = 1'b1; tl_wdata = nv_q;
        pr_we = 1'b1; pr_waddr = source_q; pr_wdata = source_q;
      end
      S_TOP: rk_raddr = source_q;
      S_TOP_W: begin
        rk_raddr = u_q; cu_raddr = u_q;
      end
      S_ADV_ARC, S_RL_ARC: arc_raddr = a_q[ArcW-1:0];
      S_ADV_AW, S_RL_AW: rk_raddr = arc_tgt;
      S_ADV_RW: begin
        pr_waddr = v_q; pr_wdata = u_q; pr_we = (ru_q == rk_q + RankW'(1));
        cu_waddr = u_q; cu_wdata = a_q; cu_we = (ru_q == rk_q + RankW'(1));
      end
      S_AUG: pr_raddr = w_q;
      S_AUG_P: cu_raddr = pr_q;
      S_AUG_C: arc_raddr = cu_q[ArcW-1:0];
      S_AUG_E: begin
        arc_we = 1'b1; arc_waddr = e_q;
        arc_wdata = {arc_tgt, arc_res - aug_q[CapBits-1:0], arc_lnk};
        arc_raddr = e_q ^ ArcW'(1);
      end
      S_AUG_F: begin
        arc_we = 1'b1; arc_waddr = e_q ^ ArcW'(1);
        arc_wdata = {arc_tgt, arc_res + aug_q[CapBits-1:0], arc_lnk};
      end
      S_RL: fa_raddr = u_q;
      S_RL_RW: begin
        cu_we = (rk_q < minr_q); cu_waddr = u_q; cu_wdata = a_q;
      end
      S_RL_END: tl_raddr = ru_q;
      S_RL_T: begin
        tl_we = 1'b1; tl_waddr = ru_q; tl_wdata = tl_dec;
        rk_we = (tl_dec != '0); rk_waddr = u_q; rk_wdata = nr_c;
      end
      S_RL_T2: tl_raddr = nr_q;
      S_RL_T3: begin
        tl_we = 1'b1; tl_waddr = nr_q; tl_wdata = tl_q + RankW'(1);
        pr_raddr = u_q;
      end
      default: ;
    endcase
  end

  // memory arrays with registered reads
  always_ff @(posedge clk_i) begin
    if (arc_we) arc_mem[arc_waddr] <= arc_wdata;
    arc_q <= arc_mem[arc_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fa_we) fa_mem[fa_waddr] <= fa_wdata;
    fa_q <= fa_mem[fa_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rk_we) rk_mem[rk_waddr] <= rk_wdata;
    rk_q <= rk_mem[rk_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cu_we) cu_mem[cu_waddr] <= cu_wdata;
    cu_q <= cu_mem[cu_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (pr_we) pr_mem[pr_waddr] <= pr_wdata;
    pr_q <= pr_mem[pr_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (tl_we) tl_mem[tl_waddr] <= tl_wdata;
    tl_q <= tl_mem[tl_raddr];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodesMax;
      source_q     <= '0;
      sink_q       <= NodeW'(MaxNodes - 1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NODE_COUNT: node_count_q <= cfg_data_i;
        CFG_SOURCE:     source_q     <= cfg_data_i[NodeW-1:0];
        CFG_SINK:       sink_q       <= cfg_data_i[NodeW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      fa_vld_q    <= '0;
      fa_vld_rd_q <= 1'b0;
      ovld_q      <= 1'b0;
    end else begin
      fa_vld_rd_q <= fa_vld_q[fa_raddr];
      if (fa_we) fa_vld_q[fa_waddr] <= 1'b1;
      if (rsp_load) ovld_q <= 1'b1;
      else if (rsp_o.valid && rsp_o.ready) ovld_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            flow_q  <= '0;
            from_q  <= req_i.from_node;
            to_q    <= req_i.to_node;
            cap_q   <= req_i.capacity[CapBits-1:0];
            nv_q    <= nv_cfg;
            idx_q   <= '0;
            case (func_e'(req_i.func))
              FUNC_CLEAR: begin
                fill_q   <= '0;
                fa_vld_q <= '0;
                st_q     <= 1'b0;
                state_q  <= S_DONE;
              end
              FUNC_ADD: begin
                st_q    <= add_full;
                state_q <= add_full ? S_DONE : S_ADD0;
              end
              FUNC_RUN: begin
                st_q    <= 1'b0;
                state_q <= run_skip ? S_DONE : S_INIT_A;
              end
              default: begin
                st_q    <= 1'b0;
                state_q <= S_DONE;
              end
            endcase
          end
        end
        // append the arc pair
        S_ADD0: state_q <= S_ADD1;
        S_ADD1: state_q <= S_ADD2;
        S_ADD2: begin
          fill_q  <= fill_q + PtrW'(2);
          state_q <= S_DONE;
        end
        // reset ranks, tallies and current arcs
        S_INIT_A: state_q <= S_INIT_B;
        S_INIT_B: begin
          idx_q   <= idx_q + RankW'(1);
          state_q <= (idx_q == NodesMax) ? S_START : S_INIT_A;
        end
        S_START: begin
          u_q     <= source_q;
          aug_q   <= AugStart;
          state_q <= S_TOP;
        end
        S_TOP: state_q <= S_TOP_W;
        S_TOP_W: state_q <= (rk_q >= nv_q) ? S_DONE : S_ADV_W;
        S_ADV_W: begin
          ru_q    <= rk_q;
          a_q     <= cu_q;
          state_q <= S_ADV_ARC;
        end
        // scan for an admissible arc from the current arc onward
        S_ADV_ARC: state_q <= (a_q >= fill_q) ? S_RL : S_ADV_AW;
        S_ADV_AW: begin
          v_q    <= arc_tgt;
          res_q  <= arc_res;
          link_q <= arc_lnk;
          if (arc_ok) state_q <= S_ADV_RW;
          else begin
            a_q     <= arc_lnk;
            state_q <= S_ADV_ARC;
          end
        end
        S_ADV_RW: begin
          if (ru_q == rk_q + RankW'(1)) begin
            aug_q <= aug_n;
            u_q   <= v_q;
            w_q   <= sink_q;
            if (v_q == sink_q) begin
              flow_q  <= flow_q + aug_n[FlowW-1:0];
              state_q <= S_AUG;
            end else state_q <= S_TOP;
          end else begin
            a_q     <= link_q;
            state_q <= S_ADV_ARC;
          end
        end
        // push the bottleneck back along the predecessor chain
        S_AUG: begin
          if (w_q == source_q) begin
            u_q     <= source_q;
            aug_q   <= AugStart;
            state_q <= S_TOP;
          end else state_q <= S_AUG_P;
        end
        S_AUG_P: begin
          w_q     <= pr_q;
          state_q <= S_AUG_C;
        end
        S_AUG_C: begin
          e_q     <= cu_q[ArcW-1:0];
          state_q <= S_AUG_E;
        end
        S_AUG_E: state_q <= S_AUG_F;
        S_AUG_F: state_q <= S_AUG;
        // relabel: find the lowest reachable rank over all arcs of u
        S_RL: begin
          minr_q  <= nv_q;
          state_q <= S_RL_W;
        end
        S_RL_W: begin
          a_q     <= fa_ptr;
          state_q <= S_RL_ARC;
        end
        S_RL_ARC: state_q <= (a_q >= fill_q) ? S_RL_END : S_RL_AW;
        S_RL_AW: begin
          link_q <= arc_lnk;
          if (arc_ok) state_q <= S_RL_RW;
          else begin
            a_q     <= arc_lnk;
            state_q <= S_RL_ARC;
          end
        end
        S_RL_RW: begin
          if (rk_q < minr_q) minr_q <= rk_q;
          a_q     <= link_q;
          state_q <= S_RL_ARC;
        end
        S_RL_END: state_q <= S_RL_T;
        S_RL_T: begin
          nr_q    <= nr_c;
          state_q <= (tl_dec == '0) ? S_DONE : S_RL_T2;
        end
        S_RL_T2: state_q <= S_RL_T3;
        S_RL_T3: state_q <= S_RL_P;
        S_RL_P: begin
          u_q     <= pr_q;
          state_q <= S_TOP;
        end
        // hand the result over once the output register is free
        S_DONE: begin
          if (rsp_load) begin
            rsp_st_q   <= st_q;
            rsp_flow_q <= flow_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // checks
  a_fill_even : assert property (@(posedge clk_i) disable iff (!rst_ni) !fill_q[0])
    else $error("arc fill is odd");
  a_fill_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= PtrW'(MaxArcs)) else $error("arc fill beyond table");
  a_state_hot : assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_fire |=> !req_i.ready) else $error("request taken while busy");

endmodule
